### sv/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg : shared types and constants
// Field widths, register indexes and reset values for the button debounce
// and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int NUM_BUTTONS_DEF = 3;

   localparam int RAW_W   = 3;
   localparam int TICK_W  = 32;
   localparam int CNT_W   = 8;
   localparam int BIDX_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   localparam logic [CNT_W-1:0]  DEBOUNCE_COUNT_RST   = 8'd3;
   localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 32'd1000;

   typedef struct packed {
      logic release_evt;
      logic long_press;
   } lane_evt_type;

endpackage

### sv/bdpc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_lane : per-button debounce core
// Tracks candidate and stable levels, agreement count and press time for
// one button; flags a release and whether it was a long press.
// ----------------------------------------------------------------------------
module bdpc_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          pressed,
   input  logic [bdpc_pkg::TICK_W-1:0]   now_ticks,
   input  logic [bdpc_pkg::CNT_W-1:0]    debounce_count,
   input  logic [bdpc_pkg::TICK_W-1:0]   long_press_ticks,
   output bdpc_pkg::lane_evt_type        evt
);
   import bdpc_pkg::*;

   logic              cand_ff,   cand_in;
   logic              stable_ff, stable_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [TICK_W-1:0] ptime_ff,  ptime_in;
   logic [CNT_W-1:0]  count_inc;
   logic [TICK_W-1:0] held;
   logic              flip;

   always_comb begin
      cand_in   = cand_ff;
      stable_in = stable_ff;
      count_in  = count_ff;
      ptime_in  = ptime_ff;
      evt       = '0;
      count_inc = (count_ff < debounce_count) ? CNT_W'(count_ff + 1'b1) : count_ff;
      held      = now_ticks - ptime_ff;
      flip      = 1'b0;
      if (accept) begin
         if (pressed != cand_ff) begin
            cand_in  = pressed;
            count_in = CNT_W'(1);
         end else begin
            count_in = count_inc;
            flip     = (count_inc >= debounce_count) && (stable_ff != cand_ff);
            if (flip) begin
               stable_in = cand_ff;
               if (cand_ff) begin
                  ptime_in = now_ticks;
               end else begin
                  evt.release_evt = 1'b1;
                  evt.long_press  = (held >= long_press_ticks);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= 1'b0;
         stable_ff <= 1'b0;
         count_ff  <= '0;
         ptime_ff  <= '0;
      end else begin
         cand_ff   <= cand_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
         ptime_ff  <= ptime_in;
      end
   end

endmodule

### sv/bdpc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_merge : release event merger
// Holds the release flags of one poll and hands them out one per cycle in
// button order while rsp_stall is low, marking the final one.
// ----------------------------------------------------------------------------
module bdpc_merge #(
   parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  bdpc_pkg::lane_evt_type [NUM_BUTTONS-1:0] evt,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [bdpc_pkg::BIDX_W-1:0]            rsp_button_index,
   output logic                                   rsp_long_press,
   output logic                                   rsp_last_event,
   output logic                                   busy
);
   import bdpc_pkg::*;

   logic [NUM_BUTTONS-1:0] pend_ff, pend_in;
   logic [NUM_BUTTONS-1:0] long_ff, long_in;
   logic [NUM_BUTTONS-1:0] evt_valid, evt_long;
   logic [NUM_BUTTONS-1:0] sel_mask, rest, remain;
   logic                   found;
   logic                   pop;

   always_comb begin
      sel_mask         = '0;
      found            = 1'b0;
      rsp_button_index = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         evt_valid[i] = evt[i].release_evt;
         evt_long[i]  = evt[i].long_press;
         if (!found && pend_ff[i]) begin
            found            = 1'b1;
            sel_mask[i]      = 1'b1;
            rsp_button_index = BIDX_W'(i);
         end
      end
   end

   assign rsp_valid      = |pend_ff;
   assign rsp_long_press = |(long_ff & sel_mask);
   assign rest           = pend_ff & ~sel_mask;
   assign rsp_last_event = ~|rest;
   assign pop            = rsp_valid && !rsp_stall;
   assign remain         = pop ? rest : pend_ff;
   assign busy           = |remain;
   assign pend_in        = load ? evt_valid : remain;
   assign long_in        = load ? evt_long  : long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      long_ff <= long_in;
   end

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_last_event && !load) |=> !rsp_valid)
      else $error("events left after last_event");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (pop && !rsp_last_event) |=> rsp_valid)
      else $error("event lost before last_event");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid || (pop && rsp_last_event)))
      else $error("new poll loaded over pending events");

endmodule

### sv/button_debounce_press_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top : button debounce and press classifier
// Debounces active-low button levels per poll and reports each release as
// a short or long press.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_*): one poll with raw levels and the tick time.
//  Response channel (rsp_*): one release event per response, in button
//  order; rsp_last_event marks the final event of a poll. Polls without a
//  release produce no response.
//  CSR port: csr_wr_en writes csr_wdata to register csr_index (0 debounce
//  count, 1 long-press ticks); other indexes are ignored. Write only idle.
//  Latency: events of a poll appear the cycle after it is accepted.
//  Throughput: a poll is taken every cycle while each causes at most one
//  event and rsp_stall is low; else the poll holds the event register until
//  its last event is taken, and the next request is taken in that cycle.
//  One lane per button does the debounce update and registers its state.
//  Stall: rsp_stall holds the current event; req_stall rises while events
//  other than the one being taken remain.
//  Reset: clears all button state, pending events and loads register
//  defaults (3 polls, 1000 ticks).
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top #(
   parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdpc_pkg::RAW_W-1:0]         req_raw_levels,
   input  logic [bdpc_pkg::TICK_W-1:0]        req_now_ticks,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdpc_pkg::BIDX_W-1:0]        rsp_button_index,
   output logic                               rsp_long_press,
   output logic                               rsp_last_event,
   input  logic                               csr_wr_en,
   input  logic [bdpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bdpc_pkg::*;

   logic [CNT_W-1:0]  debounce_ff,   debounce_in;
   logic [TICK_W-1:0] long_ticks_ff, long_ticks_in;
   logic              accept;
   logic              busy;
   lane_evt_type [NUM_BUTTONS-1:0] evt;

   always_comb begin
      debounce_in   = debounce_ff;
      long_ticks_in = long_ticks_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_DEBOUNCE_COUNT) begin
            debounce_in = csr_wdata[CNT_W-1:0];
         end
         if (csr_index == CSR_LONG_PRESS_TICKS) begin
            long_ticks_in = csr_wdata[TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_COUNT_RST;
         long_ticks_ff <= LONG_PRESS_TICKS_RST;
      end else begin
         debounce_ff   <= debounce_in;
         long_ticks_ff <= long_ticks_in;
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      logic pressed;
      if (g < RAW_W) begin : g_pin
         assign pressed = ~req_raw_levels[g];
      end else begin : g_nopin
         assign pressed = 1'b1;
      end

      bdpc_lane u_lane (
         .clock            (clock),
         .reset            (reset),
         .accept           (accept),
         .pressed          (pressed),
         .now_ticks        (req_now_ticks),
         .debounce_count   (debounce_ff),
         .long_press_ticks (long_ticks_ff),
         .evt              (evt[g])
      );
   end

   bdpc_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .evt              (evt),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_button_index (rsp_button_index),
      .rsp_long_press   (rsp_long_press),
      .rsp_last_event   (rsp_last_event),
      .busy             (busy)
   );

endmodule

### verif/tb_button_debounce_press_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier_top : debounce / press classifier bench
// Drives polls of raw button levels and tick times, predicts the release
// events from its own per-button debounce state, and compares every event
// in order. Covers directed edge cases and randomized bounce sequences
// under several register settings, with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_classifier_top;
   import bdpc_pkg::*;

   localparam int NB          = NUM_BUTTONS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYC  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      logic [BIDX_W-1:0] button_index;
      logic              long_press;
      logic              last_event;
   } release_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [RAW_W-1:0]      req_raw_levels = '1;
   logic [TICK_W-1:0]     req_now_ticks = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BIDX_W-1:0]     rsp_button_index;
   logic                  rsp_long_press;
   logic                  rsp_last_event;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted button state and registers
   logic [CNT_W-1:0]  cfg_debounce   = DEBOUNCE_COUNT_RST;
   logic [TICK_W-1:0] cfg_long_ticks = LONG_PRESS_TICKS_RST;
   logic              cand_lvl   [NB] = '{default: 1'b0};
   logic              stable_lvl [NB] = '{default: 1'b0};
   logic [CNT_W-1:0]  agree_cnt  [NB] = '{default: '0};
   logic [TICK_W-1:0] press_tick [NB] = '{default: '0};

   release_type release_q[$];

   int                fail_count  = 0;
   int                cycle_count = 0;
   bit                idle_on     = 1'b1;
   logic [TICK_W-1:0] tick_now    = '0;

   // random sequence state per button
   logic              seq_pressed [NB] = '{default: 1'b0};
   int                seq_run     [NB] = '{default: 0};

   button_debounce_press_classifier_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_levels   (req_raw_levels),
      .req_now_ticks    (req_now_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_button_index (rsp_button_index),
      .rsp_long_press   (rsp_long_press),
      .rsp_last_event   (rsp_last_event),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_button_debounce_press_classifier_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && idle_on && ($urandom_range(99) < 11);
   end

   task automatic note_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_rsp
      release_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (release_q.size() == 0) begin
            note_error($sformatf("unexpected event idx=%0d long=%0b last=%0b",
               rsp_button_index, rsp_long_press, rsp_last_event));
         end else begin
            want = release_q.pop_front();
            if (rsp_button_index !== want.button_index ||
                rsp_long_press !== want.long_press ||
                rsp_last_event !== want.last_event)
               note_error($sformatf(
                  "event mismatch exp idx=%0d long=%0b last=%0b got idx=%0d long=%0b last=%0b",
                  want.button_index, want.long_press, want.last_event,
                  rsp_button_index, rsp_long_press, rsp_last_event));
         end
      end
   end

   // debounce update of one poll; queues the release events it causes
   task automatic classify_poll(input logic [RAW_W-1:0] raw, input logic [TICK_W-1:0] now);
      release_type  ev;
      logic         pressed;
      int           n_new;
      n_new = 0;
      for (int i = 0; i < NB; i++) begin
         pressed = ~raw[i];
         if (pressed != cand_lvl[i]) begin
            cand_lvl[i]  = pressed;
            agree_cnt[i] = 8'd1;
         end else begin
            if (agree_cnt[i] < cfg_debounce) agree_cnt[i] = agree_cnt[i] + 8'd1;
            if (agree_cnt[i] >= cfg_debounce && stable_lvl[i] != cand_lvl[i]) begin
               stable_lvl[i] = cand_lvl[i];
               if (stable_lvl[i]) begin
                  press_tick[i] = now;
               end else begin
                  ev.button_index = i[BIDX_W-1:0];
                  ev.long_press   = (TICK_W'(now - press_tick[i]) >= cfg_long_ticks);
                  ev.last_event   = 1'b0;
                  release_q.push_back(ev);
                  n_new++;
               end
            end
         end
      end
      if (n_new > 0) release_q[release_q.size() - 1].last_event = 1'b1;
   endtask

   task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [TICK_W-1:0] now);
      while (idle_on && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_levels <= raw;
      req_now_ticks  <= now;
      do @(posedge clock); while (req_stall);
      classify_poll(raw, now);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (release_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_COUNT:   cfg_debounce   = val[CNT_W-1:0];
         CSR_LONG_PRESS_TICKS: cfg_long_ticks = val[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic hold_level(input logic [RAW_W-1:0] raw, input logic [TICK_W-1:0] t0,
                             input int polls);
      for (int k = 0; k < polls; k++) send_poll(raw, t0 + k);
   endtask

   // staggered presses, all three released together, long/short at the boundary
   task automatic test_basic_release();
      hold_level(3'b110, 32'd0, 3);         // button 0 pressed at tick 2
      hold_level(3'b000, 32'd10, 3);        // buttons 1 and 2 pressed at tick 12
      hold_level(3'b111, 32'd1000, 3);      // release at 1002: 1000 long, 990 short
      send_poll(3'b110, 32'd1100);          // bounce, no stable change
      send_poll(3'b111, 32'd1101);
      send_poll(3'b110, 32'd1102);
      send_poll(3'b111, 32'd1103);
   endtask

   // zero and maximal long-press thresholds, tick wrap, fastest debounce
   task automatic test_threshold_extremes();
      write_reg(CSR_DEBOUNCE_COUNT, 32'd1);
      write_reg(CSR_LONG_PRESS_TICKS, 32'd0);
      hold_level(3'b011, 32'hFFFF_FFFE, 2);
      hold_level(3'b111, 32'hFFFF_FFFE, 2); // zero held time, still long
      write_reg(CSR_LONG_PRESS_TICKS, 32'hFFFF_FFFF);
      hold_level(3'b101, 32'd4, 2);         // press recorded at 5
      hold_level(3'b111, 32'd3, 2);         // release at 4: held wraps to all ones
      hold_level(3'b110, 32'd4, 2);
      hold_level(3'b111, 32'h8000_0000, 2); // short
   endtask

   // zero debounce count and writes to unused register slots
   task automatic test_zero_debounce();
      write_reg(CSR_DEBOUNCE_COUNT, 32'h0000_FF00);
      write_reg(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_B, 32'h5A5A_5A5A);
      write_reg(CSR_LONG_PRESS_TICKS, 32'd100);
      hold_level(3'b000, 32'd50, 2);
      hold_level(3'b111, 32'd140, 2);
      hold_level(3'b010, 32'd200, 2);
      hold_level(3'b111, 32'd299, 2);
   endtask

   // threshold dropped below a running count flips the level at once
   task automatic test_threshold_lowered();
      write_reg(CSR_DEBOUNCE_COUNT, 32'd5);
      hold_level(3'b110, 32'd1000, 4);
      write_reg(CSR_DEBOUNCE_COUNT, 32'd2);
      send_poll(3'b110, 32'd1004);
      hold_level(3'b111, 32'd1010, 2);
   endtask

   function automatic logic [RAW_W-1:0] next_raw(input int run_lo, input int run_hi,
                                                 input int glitch_pct);
      logic [RAW_W-1:0] raw;
      for (int i = 0; i < NB; i++) begin
         if (seq_run[i] <= 0) begin
            seq_pressed[i] = ~seq_pressed[i];
            seq_run[i]     = $urandom_range(run_hi, run_lo);
         end
         seq_run[i]--;
         raw[i] = ~seq_pressed[i];
         if ($urandom_range(99) < glitch_pct) raw[i] = ~raw[i];
      end
      return raw;
   endfunction

   task automatic run_phase(input logic [CNT_W-1:0] db, input logic [TICK_W-1:0] thr,
                            input int step_max, input int polls,
                            input int run_lo, input int run_hi, input int glitch_pct);
      logic [RAW_W-1:0] raw;
      write_reg(CSR_DEBOUNCE_COUNT, {24'd0, db});
      write_reg(CSR_LONG_PRESS_TICKS, thr);
      for (int k = 0; k < polls; k++) begin
         raw = next_raw(run_lo, run_hi, glitch_pct);
         if ($urandom_range(99) < 4) tick_now = $urandom();
         else tick_now = tick_now + $urandom_range(step_max, 0);
         send_poll(raw, tick_now);
      end
   endtask

   task automatic test_random_sequences();
      run_phase(8'd3, 32'd1000, 250, 30, 1, 10, 8);
      idle_on = 1'b0;
      run_phase(8'd1, 32'd0, 40, 40, 1, 5, 8);
      idle_on = 1'b1;
      run_phase(8'd0, $urandom_range(800, 50), 200, 15, 1, 5, 8);
      run_phase(8'd2, 32'hFFFF_FFFF, 1000, 15, 1, 8, 8);
      run_phase(8'd7, 32'd500, 60, 20, 1, 18, 5);
   endtask

   // largest debounce count: a long clean hold reaches it and saturates there
   task automatic test_max_debounce();
      write_reg(CSR_DEBOUNCE_COUNT, 32'd255);
      write_reg(CSR_LONG_PRESS_TICKS, 32'd200);
      hold_level(3'b000, 32'd5000, 258);
      write_reg(CSR_DEBOUNCE_COUNT, 32'd1);
      hold_level(3'b111, 32'd5454, 2);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_release();
      test_threshold_extremes();
      test_zero_debounce();
      test_threshold_lowered();
      test_random_sequences();
      test_max_debounce();
      wait_idle();
      if (fail_count == 0 && release_q.size() == 0) begin
         $display("tb_button_debounce_press_classifier_top OK");
      end else begin
         $display("tb_button_debounce_press_classifier_top NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
sv/bdpc_pkg.sv
sv/bdpc_lane.sv
sv/bdpc_merge.sv
sv/button_debounce_press_classifier_top.sv
verif/tb_button_debounce_press_classifier_top.sv
